// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/scl_pkg.sv
`default_nettype none
package scl_pkg;
  localparam int unsigned MaxSegmentsDefault = 512;
  localparam int unsigned CoordW = 32;
  typedef struct packed {
    logic signed [CoordW-1:0] pos;
    logic                     closing;
  } endpoint_t;
endpackage
`default_nettype wire

// File: rtl/scl_intf.sv
`default_nettype none
interface scl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_coord;
  logic [31:0] second_coord;
  logic        last_segment;
  modport source (output valid, first_coord, second_coord, last_segment, input ready);
  modport sink (input valid, first_coord, second_coord, last_segment, output ready);
endinterface

interface scl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] single_length;
  logic        overflow;
  modport source (output valid, single_length, overflow, input ready);
  modport sink (input valid, single_length, overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/scl_mem.sv
`default_nettype none
module scl_mem
  import scl_pkg::*;
#(
  parameter int unsigned AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire endpoint_t        wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output endpoint_t             rdata_o
);
  endpoint_t mem [2**AddrW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/single_coverage_length.sv
// Loading stores each accepted segment as two entries, one store write per endpoint.
// After the last segment an insertion sort runs over the n stored endpoints
// with at most n*n/2 shift steps, then a sweep reads the sorted endpoints
// one at a time.
// Reset clears the count, the drop flag and the control; the store needs none.
`default_nettype none
module single_coverage_length
  import scl_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  scl_in_if.sink    in_i,
  scl_out_if.source out_o
);
`include "assert_macros.svh"
  localparam int unsigned Depth = 2 * MAX_SEGMENTS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = AddrW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_WR2 = 4'd1, S_SI = 4'd2, S_SKEY = 4'd3,
    S_SRD = 4'd4, S_SCMP = 4'd5, S_SPUT = 4'd6, S_WRD = 4'd7, S_WACC = 4'd8,
    S_OUT = 4'd9;

  logic [3:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic drop_q, drop_d;
  logic signed [CoordW-1:0] b_q, b_d;
  endpoint_t key_q, key_d, prev_q, prev_d;
  logic signed [CntW:0] lvl_q, lvl_d;
  logic [31:0] tot_q, tot_d;
  logic ov_q, ov_d;
  logic we;
  logic [AddrW-1:0] wa, ra;
  endpoint_t wd, rd;
  logic fits;

  scl_mem #(.AddrW(AddrW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  assign fits = ({1'b0, cnt_q} + (CntW+1)'(2)) <= (CntW+1)'(Depth);
  assign in_i.ready = (st_q == S_IDLE);
  assign out_o.valid = (st_q == S_OUT);
  assign out_o.single_length = tot_q;
  assign out_o.overflow = ov_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; drop_d = drop_q;
    b_d = b_q; key_d = key_q; prev_d = prev_q; lvl_d = lvl_q; tot_d = tot_q; ov_d = ov_q;
    we = 1'b0; wa = cnt_q[AddrW-1:0]; wd = '{pos: in_i.first_coord, closing: 1'b0};
    ra = i_q[AddrW-1:0];
    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          b_d = in_i.second_coord;
          ov_d = in_i.last_segment;
          if (fits) begin
            we = 1'b1;
            st_d = S_WR2;
          end else begin
            drop_d = 1'b1;
            if (in_i.last_segment) begin
              i_d = CntW'(1);
              st_d = S_SI;
            end
          end
        end
      end
      S_WR2: begin
        we = 1'b1;
        wa = AddrW'(cnt_q + CntW'(1));
        wd = '{pos: b_q, closing: 1'b1};
        cnt_d = cnt_q + CntW'(2);
        i_d = CntW'(1);
        st_d = ov_q ? S_SI : S_IDLE;
      end
      S_SI: begin
        if (i_q < cnt_q) st_d = S_SKEY;
        else begin
          i_d = '0; lvl_d = '0; tot_d = '0; st_d = S_WRD;
        end
      end
      S_SKEY: begin
        key_d = rd; j_d = i_q;
        ra = AddrW'(i_q - CntW'(1));
        st_d = S_SCMP;
      end
      S_SRD: begin
        ra = AddrW'(j_q - CntW'(1));
        st_d = S_SCMP;
      end
      S_SCMP: begin
        if (rd.pos > key_q.pos) begin
          we = 1'b1; wa = j_q[AddrW-1:0]; wd = rd;
          j_d = j_q - CntW'(1);
          st_d = (j_q == CntW'(1)) ? S_SPUT : S_SRD;
        end else st_d = S_SPUT;
      end
      S_SPUT: begin
        we = 1'b1; wa = j_q[AddrW-1:0]; wd = key_q;
        i_d = i_q + CntW'(1);
        st_d = S_SI;
      end
      S_WRD: begin
        st_d = S_WACC;
      end
      S_WACC: begin
        if (i_q >= cnt_q) begin
          ov_d = drop_q; cnt_d = '0; drop_d = 1'b0; st_d = S_OUT;
        end else begin
          if (i_q != '0 && (lvl_q == 1 || lvl_q == -1))
            tot_d = tot_q + 32'(rd.pos - prev_q.pos);
          lvl_d = rd.closing ? (CntW+1)'(lvl_q - 1) : (CntW+1)'(lvl_q + 1);
          prev_d = rd;
          i_d = i_q + CntW'(1);
          ra = AddrW'(i_q + CntW'(1));
          st_d = S_WRD;
        end
      end
      S_OUT: if (out_o.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; drop_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; b_q <= b_d; key_q <= key_d; prev_q <= prev_d;
    lvl_q <= lvl_d; tot_q <= tot_d; ov_q <= ov_d;
  end

  `ASSERT_IMPL(a_cnt_even, clk_i, rst_ni, 1'b1, cnt_q[0] == 1'b0)
  `ASSERT_IMPL(a_cnt_cap, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
               out_o.valid && $stable(tot_q))
  `ASSERT_NEXT(a_clear, clk_i, rst_ni, out_o.valid, cnt_q == '0 && !drop_q)
endmodule
`default_nettype wire
